### sv/rmmst_pkg.sv
// Shared constants, types and the combine function of the min/max segment tree.
package rmmst_pkg;

  localparam int LEAVES      = 1024;
  localparam int IDX_W       = 10;
  localparam int NODE_W      = $clog2(LEAVES) + 1;
  localparam int NODES       = 2 * LEAVES;
  localparam int VAL_W       = 30;
  localparam int LVL_W       = $clog2(IDX_W + 1);
  localparam int IN_FIELDS_W = 2 * IDX_W + VAL_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VAL_W + 7) / 8) * 8;

  localparam logic [VAL_W-1:0] MIN_IDENTITY = VAL_W'(32'h3f3f3f3f);
  localparam logic [VAL_W-1:0] MAX_IDENTITY = '0;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic MODE_MIN = 1'b0;
  localparam logic MODE_MAX = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_ROOT,
    ST_QRY,
    ST_DONE
  } rmmst_state_e;

  function automatic logic [VAL_W-1:0] combine(input logic mode,
                                               input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W-1:0] r;
    if (mode == MODE_MAX) begin
      r = (a > b) ? a : b;
    end else begin
      r = (a < b) ? a : b;
    end
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] identity(input logic mode);
    return (mode == MODE_MAX) ? MAX_IDENTITY : MIN_IDENTITY;
  endfunction

endpackage

### sv/range_min_max_segment_tree.sv
// Segment tree over 1024 leaves: each item either writes one leaf (and
// recomputes its ancestors, returning the new root) or queries an inclusive
// index range, combining by minimum or maximum per the mode register. All
// nodes live in one 2048 x 30 memory with one write and one read port and a
// registered read. After reset a clearing pass zeroes the memory, one entry a
// cycle; no item is taken until it ends. A write walks one tree level per
// cycle on the read port; a query issues one node read per aligned block, at
// most 2 * log2(LEAVES) - 2 = 18, and an empty range issues none. One item is
// worked on at a time; a finished result waits in the output register while
// the next item is taken, and an item whose result finds that register still
// full holds in its last cycle until it drains.
module range_min_max_segment_tree (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_data_i,     // combine_mode
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [rmmst_pkg::IN_TDATA_W-1:0] s_axis_tdata,   // index_lo, index_hi, value
  input  logic                             s_axis_tuser,   // cmd
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [rmmst_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // result
);
  import rmmst_pkg::*;

  rmmst_state_e state_q, state_d;

  logic                mode_q;
  logic [NODE_W-1:0]   clr_q, clr_d;
  logic [NODE_W-1:0]   pos_q, pos_d;
  logic [VAL_W-1:0]    cur_q, cur_d;
  logic [IDX_W:0]      off_q, off_d;
  logic [IDX_W-1:0]    hi_q, hi_d;
  logic [VAL_W-1:0]    acc_q, acc_d;
  logic                pend_q, pend_d;
  logic [VAL_W-1:0]    res_q, res_d;
  logic                m_valid_q, m_valid_d;
  logic [VAL_W-1:0]    m_data_q, m_data_d;

  logic [VAL_W-1:0]    mem [NODES];
  logic                mem_we, mem_re;
  logic [NODE_W-1:0]   mem_waddr, mem_raddr;
  logic [VAL_W-1:0]    mem_wdata, rdata_q;

  logic                s_fire, out_free, lo_ok, range_empty, issue;
  logic [IDX_W-1:0]    in_lo, in_hi, hi_sat;
  logic [VAL_W-1:0]    in_val, comb_val;
  logic [NODE_W-1:0]   leaf_addr, parent;
  logic [IDX_W:0]      rem;
  logic [LVL_W-1:0]    lvl;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(m_data_q);

  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  assign in_lo  = s_axis_tdata[IDX_W-1:0];
  assign in_hi  = s_axis_tdata[2*IDX_W-1:IDX_W];
  assign in_val = s_axis_tdata[2*IDX_W+VAL_W-1:2*IDX_W];

  assign lo_ok       = ({1'b0, in_lo} < (IDX_W+1)'(LEAVES));
  assign hi_sat      = ({1'b0, in_hi} < (IDX_W+1)'(LEAVES)) ? in_hi : IDX_W'(LEAVES - 1);
  assign range_empty = (in_lo > hi_sat);
  assign leaf_addr   = NODE_W'(LEAVES) + NODE_W'(in_lo);

  assign comb_val = combine(mode_q, cur_q, rdata_q);
  assign parent   = pos_q >> 1;

  // Query walk: next aligned block starting at off_q that fits in the range.
  assign issue = (off_q <= {1'b0, hi_q});
  assign rem   = {1'b0, hi_q} - off_q + (IDX_W+1)'(1);

  always_comb begin
    lvl = '0;
    for (int j = 0; j <= IDX_W; j++) begin
      if (((off_q & (IDX_W+1)'((32'd1 << j) - 32'd1)) == '0) &&
          (rem >= (IDX_W+1)'(32'd1 << j))) begin
        lvl = LVL_W'(j);
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == NODE_W'(NODES - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_fire) begin
          if (s_axis_tuser == CMD_WRITE) begin
            state_d = lo_ok ? ST_UPD : ST_ROOT;
          end else begin
            state_d = range_empty ? ST_DONE : ST_QRY;
          end
        end
      end
      ST_UPD: begin
        if (parent == NODE_W'(1)) state_d = ST_DONE;
      end
      ST_ROOT: state_d = ST_DONE;
      ST_QRY: begin
        if (!issue && !pend_q) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    clr_d     = clr_q;
    pos_d     = pos_q;
    cur_d     = cur_q;
    off_d     = off_q;
    hi_d      = hi_q;
    acc_d     = acc_q;
    pend_d    = 1'b0;
    res_d     = res_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + NODE_W'(1);
      end
      ST_IDLE: begin
        if (s_fire) begin
          if (s_axis_tuser == CMD_WRITE) begin
            mem_re = 1'b1;
            if (lo_ok) begin
              mem_we    = 1'b1;
              mem_waddr = leaf_addr;
              mem_wdata = in_val;
              mem_raddr = leaf_addr ^ NODE_W'(1);
              pos_d     = leaf_addr;
              cur_d     = in_val;
            end else begin
              mem_raddr = NODE_W'(1);
            end
          end else begin
            off_d = {1'b0, in_lo};
            hi_d  = hi_sat;
            acc_d = identity(mode_q);
            res_d = identity(mode_q);
          end
        end
      end
      ST_UPD: begin
        // Sibling data is back: store the parent and fetch its sibling.
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = comb_val;
        cur_d     = comb_val;
        pos_d     = parent;
        res_d     = comb_val;
        if (parent != NODE_W'(1)) begin
          mem_re    = 1'b1;
          mem_raddr = parent ^ NODE_W'(1);
        end
      end
      ST_ROOT: res_d = rdata_q;
      ST_QRY: begin
        if (pend_q) begin
          acc_d = combine(mode_q, acc_q, rdata_q);
          res_d = combine(mode_q, acc_q, rdata_q);
        end
        if (issue) begin
          mem_re    = 1'b1;
          mem_raddr = (NODE_W'(LEAVES) + NODE_W'(off_q)) >> lvl;
          off_d     = off_q + ((IDX_W+1)'(1) << lvl);
          pend_d    = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = res_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      mode_q    <= MODE_MIN;
      clr_q     <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) mode_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    cur_q    <= cur_d;
    off_q    <= off_d;
    hi_q     <= hi_d;
    acc_q    <= acc_d;
    res_q    <= res_d;
    m_data_q <= m_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

endmodule

### sv/rmmst_chk.sv
// Port-level checker for the min/max segment tree, bound to the top level.
module rmmst_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [rmmst_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import rmmst_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // One item at a time: no new item right after one is taken.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  // Memory clearing runs first after reset.
  a_clear_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !s_axis_tready && !m_axis_tvalid)
    else $error("item path open during clearing");

  // Pad bits of the result stay zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata >> VAL_W) == '0)
    else $error("result pad bits set");

endmodule

bind range_min_max_segment_tree rmmst_chk u_rmmst_chk (.*);

### tb/tb.sv
`timescale 1ns / 100ps
// Testbench for the min/max segment tree: directed table, then random writes and queries.
module tb;
  import rmmst_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 8;
  localparam int RAND_ITEMS     = 1500;
  localparam int PHASES         = 4;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DIR_ROWS       = 24;
  localparam logic [VAL_W-1:0] VAL_TOP = '1;

  typedef enum logic {ROW_ITEM, ROW_MODE} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic             mode;
    logic             cmd;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [VAL_W-1:0] val;
    logic             typed;
    logic [VAL_W-1:0] want;
  } dir_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic                   cfg_data_i = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // index_lo, index_hi, value
  logic                   s_axis_tuser = 1'b0; // cmd
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // result

  logic [VAL_W-1:0] tree_q [NODES];
  logic             mode_q;
  logic [VAL_W-1:0] result_q [$];
  logic [VAL_W-1:0] head_result;
  int unsigned      tx_idle_pct = 0;
  int unsigned      rx_stall_pct = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      errors = 0;

  // After reset the tree is all zero, so most early answers can be read off directly.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_ITEM, MODE_MIN, CMD_QUERY, 0,    1023, 0,            1'b1, 0},
    '{ROW_ITEM, MODE_MIN, CMD_QUERY, 5,    3,    0,            1'b1, MIN_IDENTITY},
    '{ROW_ITEM, MODE_MIN, CMD_WRITE, 1023, 0,    VAL_TOP,      1'b1, 0},
    '{ROW_ITEM, MODE_MIN, CMD_QUERY, 1023, 1023, VAL_TOP,      1'b1, MIN_IDENTITY},
    '{ROW_ITEM, MODE_MIN, CMD_WRITE, 0,    1023, MIN_IDENTITY, 1'b1, 0},
    '{ROW_ITEM, MODE_MIN, CMD_QUERY, 0,    0,    0,            1'b1, MIN_IDENTITY},
    '{ROW_ITEM, MODE_MIN, CMD_QUERY, 1023, 0,    VAL_TOP,      1'b1, MIN_IDENTITY},
    '{ROW_ITEM, MODE_MIN, CMD_WRITE, 511,  512,  7,            1'b1, 0},
    '{ROW_ITEM, MODE_MIN, CMD_QUERY, 0,    1023, 0,            1'b1, 0},
    '{ROW_ITEM, MODE_MIN, CMD_QUERY, 1,    1022, 0,            1'b0, 0},
    '{ROW_MODE, MODE_MAX, CMD_WRITE, 0,    0,    0,            1'b0, 0},
    '{ROW_ITEM, MODE_MAX, CMD_QUERY, 5,    3,    0,            1'b1, MAX_IDENTITY},
    '{ROW_ITEM, MODE_MAX, CMD_QUERY, 1023, 1023, 0,            1'b1, VAL_TOP},
    '{ROW_ITEM, MODE_MAX, CMD_QUERY, 0,    1023, 0,            1'b0, 0},
    '{ROW_ITEM, MODE_MAX, CMD_WRITE, 512,  0,    30'h15555555, 1'b0, 0},
    '{ROW_ITEM, MODE_MAX, CMD_QUERY, 0,    1023, 0,            1'b0, 0},
    '{ROW_ITEM, MODE_MAX, CMD_WRITE, 1023, 0,    VAL_TOP,      1'b0, 0},
    '{ROW_ITEM, MODE_MAX, CMD_QUERY, 256,  767,  0,            1'b0, 0},
    '{ROW_ITEM, MODE_MAX, CMD_WRITE, 0,    0,    0,            1'b0, 0},
    '{ROW_MODE, MODE_MIN, CMD_WRITE, 0,    0,    0,            1'b0, 0},
    '{ROW_ITEM, MODE_MIN, CMD_QUERY, 0,    1023, 0,            1'b0, 0},
    '{ROW_ITEM, MODE_MIN, CMD_QUERY, 1,    1022, 0,            1'b0, 0},
    '{ROW_ITEM, MODE_MIN, CMD_QUERY, 3,    3,    0,            1'b0, 0},
    '{ROW_ITEM, MODE_MIN, CMD_WRITE, 1023, 0,    0,            1'b0, 0}
  };

  range_min_max_segment_tree dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  function automatic logic [VAL_W-1:0] merge_pick(input logic [VAL_W-1:0] a,
                                                  input logic [VAL_W-1:0] b);
    if (mode_q == MODE_MAX) return (a > b) ? a : b;
    return (a < b) ? a : b;
  endfunction

  function automatic logic [VAL_W-1:0] empty_value();
    return (mode_q == MODE_MAX) ? MAX_IDENTITY : MIN_IDENTITY;
  endfunction

  // Store a leaf, refresh its ancestors under the current rule, return the root.
  function automatic logic [VAL_W-1:0] tree_write(input logic [IDX_W-1:0] idx,
                                                  input logic [VAL_W-1:0] val);
    int unsigned pos;
    pos = idx + LEAVES;
    tree_q[pos] = val;
    while (pos > 1) begin
      pos = pos >> 1;
      tree_q[pos] = merge_pick(tree_q[2 * pos], tree_q[2 * pos + 1]);
    end
    return tree_q[1];
  endfunction

  // Fold aligned power-of-two blocks from left to right.
  function automatic logic [VAL_W-1:0] tree_query(input logic [IDX_W-1:0] lo,
                                                  input logic [IDX_W-1:0] hi);
    int unsigned left;
    int unsigned right;
    int unsigned node;
    int unsigned span;
    logic [VAL_W-1:0] acc;
    acc = empty_value();
    if (lo > hi) return acc;
    left  = lo + LEAVES;
    right = hi + LEAVES;
    while (left <= right) begin
      node = left;
      span = 1;
      while ((node % 2 == 0) && (right - left + 1 >= 2 * span)) begin
        span = span * 2;
        node = node >> 1;
      end
      acc  = merge_pick(acc, tree_q[node]);
      left = left + span;
    end
    return acc;
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic cmd, input logic [IDX_W-1:0] lo,
                           input logic [IDX_W-1:0] hi, input logic [VAL_W-1:0] val,
                           input logic typed, input logic [VAL_W-1:0] want);
    logic [VAL_W-1:0] calc;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = IN_TDATA_W'({val, hi, lo});
    do @(posedge clk_i); while (!s_axis_tready);
    if (cmd == CMD_WRITE) calc = tree_write(lo, val);
    else calc = tree_query(lo, hi);
    result_q.insert(result_q.size(), typed ? want : calc);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (result_q.size() != 0) @(negedge clk_i);
  endtask

  // Hold the stream until the tree is idle, then write the mode register.
  task automatic set_mode(input logic m);
    s_axis_tvalid = 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = m;
    do @(posedge clk_i); while (!cfg_ready_o);
    mode_q = m;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_random();
    logic             cmd;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [VAL_W-1:0] val;
    int unsigned      a;
    int unsigned      b;
    int unsigned      reach;
    a   = $urandom_range(LEAVES - 1);
    b   = $urandom_range(LEAVES - 1);
    cmd = $urandom_range(1) ? CMD_QUERY : CMD_WRITE;
    case ($urandom_range(15))
      0:       val = '0;
      1:       val = VAL_TOP;
      2:       val = MIN_IDENTITY;
      3:       val = MIN_IDENTITY - VAL_W'(1);
      4:       val = MIN_IDENTITY + VAL_W'(1);
      5, 6:    val = VAL_W'($urandom);
      default: val = VAL_W'($urandom_range(MIN_IDENTITY - 1));
    endcase
    lo = IDX_W'(a);
    hi = IDX_W'(b);
    if (cmd == CMD_QUERY) begin
      case ($urandom_range(9))
        0: begin
          lo = IDX_W'($urandom_range(LEAVES - 1, 1));
          hi = IDX_W'($urandom_range(lo - 1, 0));
        end
        1: begin
          lo = '0;
          hi = IDX_W'(LEAVES - 1);
        end
        2: hi = IDX_W'(a);
        3, 4, 5: begin
          reach = a + $urandom_range(31);
          hi    = (reach > LEAVES - 1) ? IDX_W'(LEAVES - 1) : IDX_W'(reach);
        end
        default: begin
          lo = (a < b) ? IDX_W'(a) : IDX_W'(b);
          hi = (a < b) ? IDX_W'(b) : IDX_W'(a);
        end
      endcase
    end
    send_item(cmd, lo, hi, val, 1'b0, '0);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        $display("%0t: result with none pending, expected none, got %h", $time,
                 m_axis_tdata[VAL_W-1:0]);
        errors++;
      end else begin
        head_result = result_q.pop_front();
        if (m_axis_tdata[VAL_W-1:0] !== head_result) begin
          $display("%0t: result mismatch, expected %h, got %h", $time, head_result,
                   m_axis_tdata[VAL_W-1:0]);
          errors++;
        end
      end
    end
  end

  // Count cycles with no handshake on any channel.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NODES; i++) tree_q[i] = '0;
    mode_q = MODE_MIN;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    set_mode(MODE_MIN);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_MODE) begin
        set_mode(dir_rows[i].mode);
      end else begin
        send_item(dir_rows[i].cmd, dir_rows[i].lo, dir_rows[i].hi, dir_rows[i].val,
                  dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Idle mixes per phase: none, sender sparse, receiver stalling, both moderate.
    for (int p = 0; p < PHASES; p++) begin
      set_mode((p % 2 == 0) ? MODE_MAX : MODE_MIN);
      case (p)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 86;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 86;
        end
        default: begin
          tx_idle_pct  = 32;
          rx_stall_pct = 32;
        end
      endcase
      repeat (RAND_ITEMS / PHASES) send_random();
    end

    s_axis_tvalid = 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### range_min_max_segment_tree.f
sv/rmmst_pkg.sv
sv/range_min_max_segment_tree.sv
sv/rmmst_chk.sv
tb/tb.sv
